[rtl/core/wsc_pkg.sv]
`default_nettype none
package wsc_pkg;

	localparam int ADDR_W   = 63;
	localparam int SECTOR_W = 5;
	localparam int COUNT_W  = 6;
	localparam int SHIFT_W  = 4;

	localparam int SECTOR_BYTES_DEF = 32;
	localparam int MAX_LANES_DEF    = 32;

	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd5;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd10;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd7;

	// widest in-line offset, at the largest line size
	localparam int OFS_W = 10;

	typedef struct packed {
		logic [ADDR_W-1:0]   line;
		logic [SECTOR_W-1:0] sector;
	} pair_t;

	typedef struct packed {
		logic shift;
		logic live;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/warp_sector_coalescer_unit.sv]
// A taken lane is held in the lane register, then passes to the output register.
// Throughput: one lane address per cycle while the output does not stall; the
// new pair is compared against every live cell of the row at once and, when
// new and the row is not full, inserted at its head.
// Reset: line_shift returns to 7 and the distinct-pair count clears; stored
// pairs are not cleared, only the first count cells take part in a compare.
`default_nettype none
module warp_sector_coalescer_unit #(
	parameter int MAX_LANES    = wsc_pkg::MAX_LANES_DEF,
	parameter int SECTOR_BYTES = wsc_pkg::SECTOR_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [wsc_pkg::SHIFT_W-1:0]   cfg_line_shift,

	input  wire logic                          lane_valid,
	output logic                               lane_stall,
	input  wire logic [wsc_pkg::ADDR_W-1:0]    lane_address,
	input  wire logic                          last,

	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               is_new,
	output logic [wsc_pkg::ADDR_W-1:0]         line_address,
	output logic [wsc_pkg::SECTOR_W-1:0]       sector_index,
	output logic                               end_of_access,
	output logic [wsc_pkg::COUNT_W-1:0]        unique_count
);

	localparam int CAP = (MAX_LANES < 63) ? MAX_LANES : 63;
	localparam logic [wsc_pkg::COUNT_W-1:0] CAP_C = wsc_pkg::COUNT_W'(CAP);

	logic [wsc_pkg::SHIFT_W-1:0] line_shift_q;
	logic [wsc_pkg::COUNT_W-1:0] seen_cnt_q;

	logic           s1_valid;
	wsc_pkg::pair_t pair_s1;
	logic           last_s1;

	logic                        out_valid_q;
	logic                        is_new_q;
	wsc_pkg::pair_t              out_pair_q;
	logic                        eoa_q;
	logic [wsc_pkg::COUNT_W-1:0] count_q;

	wsc_pkg::pair_t              in_pair;
	logic                        s1_adv;
	logic                        lane_xfer;
	logic                        hit;
	logic                        ins;
	logic [wsc_pkg::COUNT_W-1:0] cnt_next;

	wsc_pkg::pair_t      row [MAX_LANES];
	logic [MAX_LANES-1:0] match;

	assign cfg_ready  = 1'b1;
	assign s1_adv     = s1_valid && (!out_valid_q || !result_stall);
	assign lane_stall = s1_valid && !s1_adv;
	assign lane_xfer  = lane_valid && !lane_stall;

	wsc_split #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_split (
		.addr      (lane_address),
		.line_shift(line_shift_q),
		.pair      (in_pair)
	);

	assign hit      = |match;
	assign ins      = s1_adv && !hit && (seen_cnt_q < CAP_C);
	assign cnt_next = seen_cnt_q + wsc_pkg::COUNT_W'(ins);

	for (genvar i = 0; i < MAX_LANES; i++) begin : g_cell
		wsc_pkg::cell_ctrl_t ctrl;
		assign ctrl = '{shift: ins, live: (seen_cnt_q > wsc_pkg::COUNT_W'(i))};
		if (i == 0) begin : g_head
			wsc_cell u_cell (
				.clk  (clk),
				.ctrl (ctrl),
				.key  (pair_s1),
				.prev (pair_s1),
				.entry(row[i]),
				.match(match[i])
			);
		end else begin : g_body
			wsc_cell u_cell (
				.clk  (clk),
				.ctrl (ctrl),
				.key  (pair_s1),
				.prev (row[i-1]),
				.entry(row[i]),
				.match(match[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_shift_q <= wsc_pkg::SHIFT_RST;
			seen_cnt_q   <= '0;
			s1_valid     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				line_shift_q <= cfg_line_shift;
			end
			if (lane_xfer) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				seen_cnt_q  <= last_s1 ? '0 : cnt_next;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lane_xfer) begin
			pair_s1 <= in_pair;
			last_s1 <= last;
		end
		if (s1_adv) begin
			is_new_q   <= !hit;
			out_pair_q <= pair_s1;
			eoa_q      <= last_s1;
			count_q    <= cnt_next;
		end
	end

	assign result_valid  = out_valid_q;
	assign is_new        = is_new_q;
	assign line_address  = out_pair_q.line;
	assign sector_index  = out_pair_q.sector;
	assign end_of_access = eoa_q;
	assign unique_count  = count_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		seen_cnt_q <= CAP_C)
		else $error("distinct-pair count above list capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> seen_cnt_q == '0)
		else $error("count not cleared after end of access");

	a_hit_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && hit && !last_s1 |=> seen_cnt_q == $past(seen_cnt_q))
		else $error("count changed on a repeated pair");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && result_stall |=> s1_valid && $stable(pair_s1))
		else $error("stage 1 item lost under output stall");

endmodule
`default_nettype wire

[rtl/core/wsc_split.sv]
`default_nettype none
module wsc_split #(
	parameter int SECTOR_BYTES = wsc_pkg::SECTOR_BYTES_DEF
) (
	input  wire logic [wsc_pkg::ADDR_W-1:0]  addr,
	input  wire logic [wsc_pkg::SHIFT_W-1:0] line_shift,
	output wsc_pkg::pair_t                   pair
);

	// offset / SECTOR_BYTES as multiply by rounded-up reciprocal, exact for OFS_W-bit offsets
	localparam int REC_SHIFT = wsc_pkg::OFS_W + $clog2(SECTOR_BYTES);
	localparam int RECIP     = ((1 << REC_SHIFT) + SECTOR_BYTES - 1) / SECTOR_BYTES;
	localparam int RECIP_W   = wsc_pkg::OFS_W + 2;
	localparam int PROD_W    = wsc_pkg::OFS_W + RECIP_W;

	logic [wsc_pkg::SHIFT_W-1:0] sh;
	logic [wsc_pkg::ADDR_W-1:0]  lo_mask;
	logic [wsc_pkg::OFS_W-1:0]   ofs;
	logic [PROD_W-1:0]           prod;

	always_comb begin
		if (line_shift < wsc_pkg::SHIFT_MIN) begin
			sh = wsc_pkg::SHIFT_MIN;
		end else if (line_shift > wsc_pkg::SHIFT_MAX) begin
			sh = wsc_pkg::SHIFT_MAX;
		end else begin
			sh = line_shift;
		end
		lo_mask     = (wsc_pkg::ADDR_W'(1) << sh) - wsc_pkg::ADDR_W'(1);
		ofs         = addr[wsc_pkg::OFS_W-1:0] & lo_mask[wsc_pkg::OFS_W-1:0];
		prod        = PROD_W'(ofs) * PROD_W'(RECIP);
		pair.line   = addr & ~lo_mask;
		pair.sector = prod[REC_SHIFT +: wsc_pkg::SECTOR_W];
	end

endmodule
`default_nettype wire

[rtl/core/wsc_cell.sv]
`default_nettype none
module wsc_cell (
	input  wire logic                clk,
	input  wire wsc_pkg::cell_ctrl_t ctrl,
	input  wire wsc_pkg::pair_t      key,
	input  wire wsc_pkg::pair_t      prev,
	output wsc_pkg::pair_t           entry,
	output logic                     match
);

	wsc_pkg::pair_t entry_q;

	// on insert the whole row moves one place down
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;
	assign match = ctrl.live && (entry_q == key);

endmodule
`default_nettype wire
